// File: hdl/ttcmap_pkg.sv
// ----------------------------------------------------------------------------
// ttcmap_pkg
// shared types and constants for the cmap glyph lookup engine
// ----------------------------------------------------------------------------
package ttcmap_pkg;

  localparam int unsigned TableBytesDef = 65536;

  localparam logic [1:0] STATUS_OK       = 2'd0;
  localparam logic [1:0] STATUS_BAD_FMT  = 2'd1;
  localparam logic [1:0] STATUS_READ_OOR = 2'd2;

  localparam logic [15:0] FMT_BYTE  = 16'd0;
  localparam logic [15:0] FMT_SEG   = 16'd4;
  localparam logic [15:0] FMT_GROUP = 16'd12;

  localparam logic [20:0] SYMBOL_BASE  = 21'h0F000;
  localparam logic [20:0] SYMBOL_LIMIT = 21'h00100;

  localparam logic CFG_SYMBOL_FONT   = 1'b0;
  localparam logic CFG_TABLE_PRESENT = 1'b1;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_RD,       // issue byte reads of a field
    ST_RD_WAIT,  // wait for last byte
    ST_FORMAT,
    ST_F4_SEGX2,
    ST_F4_END,
    ST_F4_START,
    ST_F4_DELTA,
    ST_F4_RO,
    ST_F4_ID,
    ST_F12_N,
    ST_F12_MID,
    ST_F12_FIRST,
    ST_F12_LAST,
    ST_F12_GLYPH,
    ST_F0_BYTE,
    ST_PASS_DONE,
    ST_OUT
  } state_t;

endpackage

// File: hdl/ttcmap_if.sv
// ----------------------------------------------------------------------------
// ttcmap channel interfaces
// valid/ready channels for input words, result words and config writes
// ----------------------------------------------------------------------------
interface ttcmap_in_if;
  logic        valid;
  logic        ready;
  logic        mode;
  logic [15:0] table_address;
  logic [7:0]  table_byte;
  logic [20:0] code_point;
  logic        last_in_string;
  modport source (output valid, mode, table_address, table_byte, code_point,
                  last_in_string, input ready);
  modport sink (input valid, mode, table_address, table_byte, code_point,
                last_in_string, output ready);
endinterface

interface ttcmap_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] glyph_index;
  logic [1:0]  status;
  logic        last_out;
  modport source (output valid, glyph_index, status, last_out, input ready);
  modport sink (input valid, glyph_index, status, last_out, output ready);
endinterface

interface ttcmap_cfg_if;
  logic       valid;
  logic       ready;
  logic       index;
  logic [0:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// File: hdl/ttcmap_ram.sv
// ----------------------------------------------------------------------------
// ttcmap_ram
// generic single-port ram with registered read
// ----------------------------------------------------------------------------
module ttcmap_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 65536
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] addr,
  input  logic [Width-1:0]         wdata,
  output logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];

  // write or read one word
  always_ff @(posedge clk) begin
    if (we) mem[addr] <= wdata;
    rdata <= mem[addr];
  end
endmodule

// File: hdl/truetype_cmap_glyph_lookup_top.sv
// ----------------------------------------------------------------------------
// truetype_cmap_glyph_lookup_top
// cmap subtable glyph lookup (formats 0, 4, 12) over a byte memory
// ----------------------------------------------------------------------------
// a field is read one byte at a time, most significant byte first, and is used once
//   its last byte has arrived; a symbol retry adds a second pass over the subtable.
// throughput: one item at a time; the next word is taken while a result waits.
// reset: clears control, result valid and both config registers, not memory.
module truetype_cmap_glyph_lookup_top
  import ttcmap_pkg::*;
#(
  parameter int unsigned TABLE_BYTES = TableBytesDef
) (
  input logic          clk,
  input logic          rst,
  ttcmap_in_if.sink    in_ch,
  ttcmap_out_if.source out_ch,
  ttcmap_cfg_if.sink   cfg
);
  localparam int unsigned AW = $clog2(TABLE_BYTES);

  state_t state, state_next, ret, ret_next;

  logic        symbol_font, table_present;
  logic [20:0] code, code_next;
  logic        retried, retried_next;
  logic        last, last_next;
  logic        fault, fault_next, badfmt, badfmt_next;
  logic [31:0] glyph, glyph_next;
  logic [35:0] rd_addr, rd_addr_next;   // byte address of current field
  logic [2:0]  rd_cnt, rd_cnt_next;     // bytes still to issue
  logic [2:0]  rd_len, rd_len_next;
  logic [31:0] acc, acc_next;           // assembled big-endian field
  logic        pend, pend_next;         // a read issued last cycle
  logic        pend_oor, pend_oor_next;
  logic [16:0] segx2, segx2_next;
  logic [15:0] seg_i, seg_i_next, segs;
  logic [15:0] start, start_next, delta, delta_next;
  logic [35:0] ro_addr, ro_addr_next;
  logic [32:0] left, left_next, right, right_next, mid, mid_next;
  logic [31:0] first, first_next;
  logic        out_valid, out_valid_next;
  logic [31:0] out_glyph, out_glyph_next;
  logic [1:0]  out_status, out_status_next;
  logic        out_last, out_last_next;

  logic          ram_we;
  logic [AW-1:0] ram_addr;
  logic [7:0]    ram_rdata;
  logic          oor;
  logic [32:0]   mid_calc;
  logic [31:0]   wfield;
  logic [1:0]    status_calc;

  ttcmap_ram #(.Width(8), .Depth(TABLE_BYTES)) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .addr (ram_addr),
    .wdata(in_ch.table_byte),
    .rdata(ram_rdata)
  );

  assign segs     = segx2[16:1];
  assign oor      = (rd_addr >= 36'(TABLE_BYTES));
  assign mid_calc = left + ((right - left) >> 1);
  // incoming byte merged into field
  assign wfield   = {acc[23:0], (pend_oor ? 8'd0 : ram_rdata)};
  // merged status of the finished lookup
  assign status_calc = !table_present ? STATUS_OK :
                       fault ? STATUS_READ_OOR :
                       badfmt ? STATUS_BAD_FMT : STATUS_OK;

  // config registers
  always_ff @(posedge clk) begin
    if (rst) begin
      symbol_font   <= 1'b0;
      table_present <= 1'b0;
    end else if (cfg.valid && cfg.ready) begin
      if (cfg.index == CFG_SYMBOL_FONT) symbol_font <= cfg.data[0];
      else table_present <= cfg.data[0];
    end
  end
  assign cfg.ready = 1'b1;

  // state and datapath registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      pend      <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      pend      <= pend_next;
      out_valid <= out_valid_next;
    end
    ret <= ret_next; code <= code_next; retried <= retried_next;
    last <= last_next; fault <= fault_next; badfmt <= badfmt_next;
    glyph <= glyph_next; rd_addr <= rd_addr_next; rd_cnt <= rd_cnt_next;
    rd_len <= rd_len_next; acc <= acc_next; pend_oor <= pend_oor_next;
    segx2 <= segx2_next; seg_i <= seg_i_next; start <= start_next;
    delta <= delta_next; ro_addr <= ro_addr_next; left <= left_next;
    right <= right_next; mid <= mid_next; first <= first_next;
    out_glyph <= out_glyph_next; out_status <= out_status_next;
    out_last <= out_last_next;
  end

  // sequencer
  always_comb begin
    state_next = state; ret_next = ret; code_next = code;
    retried_next = retried; last_next = last; fault_next = fault;
    badfmt_next = badfmt; glyph_next = glyph; rd_addr_next = rd_addr;
    rd_cnt_next = rd_cnt; rd_len_next = rd_len; acc_next = acc;
    pend_next = 1'b0; pend_oor_next = pend_oor; segx2_next = segx2;
    seg_i_next = seg_i; start_next = start; delta_next = delta;
    ro_addr_next = ro_addr; left_next = left; right_next = right;
    mid_next = mid; first_next = first;
    out_valid_next = out_valid && !out_ch.ready;
    out_glyph_next = out_glyph; out_status_next = out_status;
    out_last_next = out_last;
    ram_we = 1'b0;
    ram_addr = rd_addr[AW-1:0];
    in_ch.ready = 1'b0;
    if (pend) acc_next = wfield;

    unique case (state)
      ST_IDLE: begin
        in_ch.ready = 1'b1;
        ram_addr = AW'(in_ch.table_address);
        if (in_ch.valid) begin
          code_next = in_ch.code_point; last_next = in_ch.last_in_string;
          fault_next = 1'b0; badfmt_next = 1'b0; retried_next = 1'b0;
          if (!in_ch.mode) begin
            ram_we = (32'(in_ch.table_address) < 32'(TABLE_BYTES));
          end else if (!table_present) begin
            glyph_next = {16'd0, in_ch.code_point[15:0]};
            state_next = ST_OUT;
          end else begin
            rd_addr_next = 36'd0; rd_cnt_next = 3'd2; acc_next = 32'd0;
            ret_next = ST_FORMAT; state_next = ST_RD;
          end
        end
      end
      ST_RD: begin
        pend_next = 1'b1; pend_oor_next = oor;
        if (oor) fault_next = 1'b1;
        rd_addr_next = rd_addr + 36'd1;
        rd_cnt_next = rd_cnt - 3'd1;
        if (rd_cnt == 3'd1) state_next = ST_RD_WAIT;
      end
      ST_RD_WAIT: state_next = ret;
      ST_FORMAT: begin
        priority if (acc[15:0] == FMT_BYTE) begin
          if (code < 21'h100) begin
            rd_addr_next = 36'd6 + 36'(code); rd_cnt_next = 3'd1;
            acc_next = 32'd0; ret_next = ST_F0_BYTE; state_next = ST_RD;
          end else begin
            glyph_next = 32'd0; state_next = ST_PASS_DONE;
          end
        end else if (acc[15:0] == FMT_SEG) begin
          if (code > 21'hFFFF) begin
            glyph_next = 32'd0; state_next = ST_PASS_DONE;
          end else begin
            rd_addr_next = 36'd6; rd_cnt_next = 3'd2; acc_next = 32'd0;
            ret_next = ST_F4_SEGX2; state_next = ST_RD;
          end
        end else if (acc[15:0] == FMT_GROUP) begin
          rd_addr_next = 36'd12; rd_cnt_next = 3'd4; acc_next = 32'd0;
          ret_next = ST_F12_N; state_next = ST_RD;
        end else begin
          badfmt_next = 1'b1; glyph_next = 32'd0; state_next = ST_PASS_DONE;
        end
      end
      ST_F0_BYTE: begin
        glyph_next = {24'd0, acc[7:0]}; state_next = ST_PASS_DONE;
      end
      ST_F4_SEGX2: begin
        segx2_next = {1'b0, acc[15:0]}; seg_i_next = 16'd0;
        if (acc[15:1] == 15'd0) begin
          glyph_next = 32'd0; state_next = ST_PASS_DONE;
        end else begin
          rd_addr_next = 36'd14; rd_cnt_next = 3'd2; acc_next = 32'd0;
          ret_next = ST_F4_END; state_next = ST_RD;
        end
      end
      ST_F4_END: begin
        if (acc[15:0] >= code[15:0]) begin
          rd_addr_next = 36'd16 + 36'(segx2) + {19'd0, seg_i, 1'b0};
          rd_cnt_next = 3'd2; acc_next = 32'd0;
          ret_next = ST_F4_START; state_next = ST_RD;
        end else if (seg_i + 16'd1 >= segs) begin
          glyph_next = 32'd0; state_next = ST_PASS_DONE;
        end else begin
          seg_i_next = seg_i + 16'd1;
          rd_addr_next = 36'd14 + {19'd0, seg_i + 16'd1, 1'b0};
          rd_cnt_next = 3'd2; acc_next = 32'd0; state_next = ST_RD;
        end
      end
      ST_F4_START: begin
        start_next = acc[15:0];
        if (acc[15:0] > code[15:0]) begin
          glyph_next = 32'd0; state_next = ST_PASS_DONE;
        end else begin
          rd_addr_next = 36'd16 + {18'd0, segx2, 1'b0} + {19'd0, seg_i, 1'b0};
          rd_cnt_next = 3'd2; acc_next = 32'd0;
          ret_next = ST_F4_DELTA; state_next = ST_RD;
        end
      end
      ST_F4_DELTA: begin
        delta_next = acc[15:0];
        ro_addr_next = 36'd16 + 36'(segx2) + {18'd0, segx2, 1'b0}
                       + {19'd0, seg_i, 1'b0};
        rd_addr_next = 36'd16 + 36'(segx2) + {18'd0, segx2, 1'b0}
                       + {19'd0, seg_i, 1'b0};
        rd_cnt_next = 3'd2; acc_next = 32'd0;
        ret_next = ST_F4_RO; state_next = ST_RD;
      end
      ST_F4_RO: begin
        if (acc[15:0] == 16'd0) begin
          glyph_next = {16'd0, delta + code[15:0]}; state_next = ST_PASS_DONE;
        end else begin
          rd_addr_next = ro_addr + 36'(acc[15:0])
                         + {19'd0, code[15:0] - start, 1'b0};
          rd_cnt_next = 3'd2; acc_next = 32'd0;
          ret_next = ST_F4_ID; state_next = ST_RD;
        end
      end
      ST_F4_ID: begin
        glyph_next = (acc[15:0] == 16'd0) ? 32'd0 : {16'd0, delta + acc[15:0]};
        state_next = ST_PASS_DONE;
      end
      ST_F12_N: begin
        left_next = 33'd0; right_next = {1'b0, acc};
        state_next = ST_F12_MID;
      end
      ST_F12_MID: begin
        if (left >= right) begin
          glyph_next = 32'd0; state_next = ST_PASS_DONE;
        end else begin
          mid_next = mid_calc;
          // group base 16 + 12*mid as (mid<<3)+(mid<<2)
          rd_addr_next = 36'd16 + {mid_calc, 3'd0} + {1'b0, mid_calc, 2'd0};
          rd_cnt_next = 3'd4; acc_next = 32'd0;
          ret_next = ST_F12_FIRST; state_next = ST_RD;
        end
      end
      ST_F12_FIRST: begin
        first_next = acc;
        if (32'(code) < acc) begin
          right_next = mid; state_next = ST_F12_MID;
        end else begin
          rd_cnt_next = 3'd4; acc_next = 32'd0;
          ret_next = ST_F12_LAST; state_next = ST_RD;
        end
      end
      ST_F12_LAST: begin
        if (32'(code) <= acc) begin
          rd_cnt_next = 3'd4; acc_next = 32'd0;
          ret_next = ST_F12_GLYPH; state_next = ST_RD;
        end else begin
          left_next = mid + 33'd1; state_next = ST_F12_MID;
        end
      end
      ST_F12_GLYPH: begin
        glyph_next = acc + (32'(code) - first); state_next = ST_PASS_DONE;
      end
      ST_PASS_DONE: begin
        if (glyph == 32'd0 && symbol_font && !retried && code < SYMBOL_LIMIT) begin
          retried_next = 1'b1; code_next = code + SYMBOL_BASE;
          rd_addr_next = 36'd0; rd_cnt_next = 3'd2; acc_next = 32'd0;
          ret_next = ST_FORMAT; state_next = ST_RD;
        end else begin
          state_next = ST_OUT;
        end
      end
      ST_OUT: begin
        // move the result into the output register once it is free
        if (!out_valid || out_ch.ready) begin
          out_valid_next = 1'b1;
          out_glyph_next = glyph;
          out_status_next = status_calc;
          out_last_next = last;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // result word
  assign out_ch.valid       = out_valid;
  assign out_ch.glyph_index = out_glyph;
  assign out_ch.status      = out_status;
  assign out_ch.last_out    = out_last;
endmodule

// File: verif/ttcmap_lookup_checker.sv
// ----------------------------------------------------------------------------
// ttcmap_lookup_checker
// watches the input, result and config channels of the cmap lookup engine,
// keeps its own copy of the subtable bytes and registers, predicts the glyph
// word of every accepted lookup and compares it with the result channel
// ----------------------------------------------------------------------------
module ttcmap_lookup_checker
  import ttcmap_pkg::*;
(
  input  logic   clk,
  input  logic   rst,
  ttcmap_in_if   in_ch,
  ttcmap_out_if  out_ch,
  ttcmap_cfg_if  cfg,
  output int     errors,
  output int     pending,
  output int     checked
);

  typedef struct {
    logic [31:0] glyph;
    logic [1:0]  status;
    logic        last;
  } glyph_word_t;

  glyph_word_t expected_glyphs[$];
  logic [7:0]  table_image [TableBytesDef];
  logic        symbol_on;
  logic        table_on;
  logic        hit_oor;
  logic        hit_bad_fmt;

  initial begin
    errors  = 0;
    pending = 0;
    checked = 0;
  end

  // byte fetch, flags reads past the end of the memory
  function automatic logic [7:0] fetch8(longint unsigned addr);
    if (addr >= TableBytesDef) begin
      hit_oor = 1'b1;
      return 8'd0;
    end
    return table_image[addr];
  endfunction

  function automatic logic [15:0] fetch16(longint unsigned addr);
    logic [7:0] hi;
    logic [7:0] lo;
    hi = fetch8(addr);
    lo = fetch8(addr + 1);
    return {hi, lo};
  endfunction

  function automatic logic [31:0] fetch32(longint unsigned addr);
    logic [15:0] hi;
    logic [15:0] lo;
    hi = fetch16(addr);
    lo = fetch16(addr + 2);
    return {hi, lo};
  endfunction

  // one pass over the subtable for one code
  function automatic logic [31:0] find_glyph(logic [31:0] code);
    logic [15:0]     fmt;
    logic [15:0]     delta;
    logic [15:0]     id;
    logic [15:0]     sum;
    logic [31:0]     first;
    longint unsigned segx2, segs, i, start, ro, ro_addr;
    longint unsigned n, left, right, mid, g;
    bit              found;
    fmt = fetch16(0);
    if (fmt == FMT_BYTE) begin
      if (code < 32'h100) return {24'd0, fetch8(6 + code)};
      return 32'd0;
    end
    if (fmt == FMT_SEG) begin
      if (code > 32'hffff) return 32'd0;
      segx2 = fetch16(6);
      segs  = segx2 >> 1;
      found = 1'b0;
      for (i = 0; i < segs; i++) begin
        if (fetch16(14 + 2 * i) >= code) begin
          found = 1'b1;
          break;
        end
      end
      if (!found) return 32'd0;
      start = fetch16(16 + segx2 + 2 * i);
      if (start > code) return 32'd0;
      delta   = fetch16(16 + 2 * segx2 + 2 * i);
      ro_addr = 16 + 3 * segx2 + 2 * i;
      ro      = fetch16(ro_addr);
      if (ro != 0) begin
        id = fetch16(ro_addr + ro + 2 * (code - start));
        if (id == 16'd0) return 32'd0;
        sum = delta + id;
        return {16'd0, sum};
      end
      sum = delta + code[15:0];
      return {16'd0, sum};
    end
    if (fmt == FMT_GROUP) begin
      n     = fetch32(12);
      left  = 0;
      right = n;
      while (left < right) begin
        mid   = left + ((right - left) >> 1);
        g     = 16 + 12 * mid;
        first = fetch32(g);
        if (code < first) begin
          right = mid;
        end else begin
          if (code <= fetch32(g + 4)) return fetch32(g + 8) + (code - first);
          left = mid + 1;
        end
      end
      return 32'd0;
    end
    hit_bad_fmt = 1'b1;
    return 32'd0;
  endfunction

  // full lookup with pass-through, symbol retry and status merge
  function automatic glyph_word_t predict_glyph(logic [20:0] cp, logic last);
    glyph_word_t w;
    logic [31:0] code;
    code     = {11'd0, cp};
    w.last   = last;
    w.status = STATUS_OK;
    if (!table_on) begin
      w.glyph = {16'd0, code[15:0]};
      return w;
    end
    hit_oor     = 1'b0;
    hit_bad_fmt = 1'b0;
    w.glyph = find_glyph(code);
    if (w.glyph == 32'd0 && symbol_on && cp < SYMBOL_LIMIT)
      w.glyph = find_glyph(code + {11'd0, SYMBOL_BASE});
    if (hit_oor) w.status = STATUS_READ_OOR;
    else if (hit_bad_fmt) w.status = STATUS_BAD_FMT;
    return w;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] want, logic [31:0] got);
    $display("%0t: mismatch on %s: expected %0h, got %0h", $realtime, what, want, got);
    errors++;
  endtask

  // result words first, then new lookups, then register writes
  always @(posedge clk) begin
    glyph_word_t want;
    if (rst) begin
      symbol_on = 1'b0;
      table_on  = 1'b0;
      expected_glyphs.delete();
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (expected_glyphs.size() == 0) begin
          report_mismatch("result word with no lookup pending", 32'd0, out_ch.glyph_index);
        end else begin
          want = expected_glyphs.pop_front();
          if (out_ch.glyph_index !== want.glyph)
            report_mismatch("glyph_index", want.glyph, out_ch.glyph_index);
          if (out_ch.status !== want.status)
            report_mismatch("status", 32'(want.status), 32'(out_ch.status));
          if (out_ch.last_out !== want.last)
            report_mismatch("last_out", 32'(want.last), 32'(out_ch.last_out));
          checked++;
        end
      end
      if (in_ch.valid && in_ch.ready) begin
        if (in_ch.mode == 1'b0)
          table_image[in_ch.table_address] = in_ch.table_byte;
        else
          expected_glyphs.push_back(predict_glyph(in_ch.code_point, in_ch.last_in_string));
      end
      if (cfg.valid && cfg.ready) begin
        if (cfg.index == CFG_SYMBOL_FONT) symbol_on = cfg.data[0];
        else table_on = cfg.data[0];
      end
    end
    pending = expected_glyphs.size();
  end

endmodule

// File: verif/tb_truetype_cmap_glyph_lookup_top.sv
// ----------------------------------------------------------------------------
// tb_truetype_cmap_glyph_lookup_top
// builds format 0, 4 and 12 subtables and unsupported headers word by word,
// then looks up code points hitting segments, gaps, symbol retries and reads
// past memory, under random idling on both sides; a checker predicts results
// ----------------------------------------------------------------------------
module tb_truetype_cmap_glyph_lookup_top;
  import ttcmap_pkg::*;

  typedef enum {
    TBL_BYTE, TBL_SEG_FULL, TBL_SEG_OPEN, TBL_GROUP, TBL_GROUP_EMPTY,
    TBL_GROUP_HUGE, TBL_BAD_FMT
  } table_kind_t;

  localparam int BYTE_CODES = 8;
  localparam int HOLD_CYCLES = 400;
  localparam int STALL_LIMIT = 6000;

  logic clk;
  logic rst;

  ttcmap_in_if  in_ch ();
  ttcmap_out_if out_ch ();
  ttcmap_cfg_if cfg ();

  int errors, pending, checked;
  int n_sent, n_writes, n_lookups, n_cfg;
  int hold_asked, hold_seen, hold_left;
  int stall_count;

  table_kind_t kind;
  logic [20:0] seg_lo [4];
  logic [20:0] seg_hi [4];
  logic [20:0] grp_lo [4];
  logic [20:0] grp_hi [4];
  int          n_groups;

  truetype_cmap_glyph_lookup_top u_dut (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg    (cfg)
  );

  ttcmap_lookup_checker u_checker (
    .clk     (clk),
    .rst     (rst),
    .in_ch   (in_ch),
    .out_ch  (out_ch),
    .cfg     (cfg),
    .errors  (errors),
    .pending (pending),
    .checked (checked)
  );

  // clock
  initial clk = 1'b0;
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // idling phase follows progress through the input words
  function automatic int idle_phase();
    if (n_sent < 230) return 0;
    if (n_sent < 460) return 1;
    return 2;
  endfunction

  // result side: random stalls plus one long hold-off on request
  initial out_ch.ready = 1'b0;
  always @(negedge clk) begin
    if (hold_asked != hold_seen) begin
      hold_seen = hold_asked;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ch.ready <= 1'b0;
    end else begin
      case (idle_phase())
        0: out_ch.ready <= ($urandom_range(99) >= 74);
        1: out_ch.ready <= ($urandom_range(99) >= 20);
        default: out_ch.ready <= 1'b1;
      endcase
    end
  end

  // watchdog on cycles without any accepted word
  always @(posedge clk) begin
    if (rst || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)
        || (cfg.valid && cfg.ready)) begin
      stall_count <= 0;
    end else begin
      stall_count <= stall_count + 1;
      if (stall_count == STALL_LIMIT) begin
        $display("%0t: no progress for %0d cycles", $realtime, STALL_LIMIT);
        $display("== FAIL ==");
        $finish;
      end
    end
  end

  // one input word, with random gaps before it
  task automatic send_word(logic mode, logic [15:0] addr, logic [7:0] b, logic [20:0] cp);
    int pct;
    @(negedge clk);
    pct = (idle_phase() == 0) ? 20 : (idle_phase() == 1) ? 74 : 0;
    while ($urandom_range(99) < pct) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid          <= 1'b1;
    in_ch.mode           <= mode;
    in_ch.table_address  <= addr;
    in_ch.table_byte     <= b;
    in_ch.code_point     <= cp;
    in_ch.last_in_string <= 1'($urandom_range(1));
    do @(posedge clk); while (!in_ch.ready);
    n_sent++;
  endtask

  task automatic write_byte(int addr, logic [7:0] b);
    send_word(1'b0, addr[15:0], b, 21'($urandom));
    n_writes++;
  endtask

  task automatic write_half(int addr, logic [15:0] v);
    write_byte(addr, v[15:8]);
    write_byte(addr + 1, v[7:0]);
  endtask

  task automatic write_word(int addr, logic [31:0] v);
    write_half(addr, v[31:16]);
    write_half(addr + 2, v[15:0]);
  endtask

  task automatic lookup(logic [20:0] cp);
    send_word(1'b1, 16'($urandom), 8'($urandom), cp);
    n_lookups++;
  endtask

  // wait until all results are back, then let trailing writes settle
  task automatic drain();
    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (64) @(negedge clk);
  endtask

  task automatic set_reg(logic idx, logic val);
    drain();
    cfg.valid <= 1'b1;
    cfg.index <= idx;
    cfg.data  <= val;
    do @(posedge clk); while (!cfg.ready);
    @(negedge clk);
    cfg.valid <= 1'b0;
    n_cfg++;
  endtask

  // subtable images; every byte a lookup can reach is written first
  task automatic build_table(table_kind_t k);
    logic [15:0] fmt;
    logic [31:0] count;
    write_byte($urandom_range(16'h8000, 16'hffff), 8'($urandom));
    write_byte('hffff, 8'($urandom));
    case (k)
      TBL_BYTE: begin
        write_half(0, FMT_BYTE);
        write_half(2, 16'($urandom));
        write_half(4, 16'($urandom));
        for (int i = 0; i < BYTE_CODES; i++)
          write_byte(6 + i, (i == 3) ? 8'd0 : 8'($urandom));
      end
      TBL_SEG_FULL, TBL_SEG_OPEN: begin
        seg_lo[0] = 21'($urandom_range(0, 16'h80));
        seg_hi[0] = seg_lo[0] + 21'($urandom_range(0, 16'h100));
        seg_lo[1] = seg_hi[0] + 21'($urandom_range(1, 16'h40));
        seg_hi[1] = seg_lo[1] + 21'd7;
        seg_lo[2] = seg_hi[1] + 21'($urandom_range(1, 16'h200));
        seg_hi[2] = seg_lo[2] + 21'($urandom_range(0, 16'h1000));
        seg_lo[3] = 21'($urandom_range(seg_hi[2] + 1, 16'hf000));
        seg_hi[3] = (k == TBL_SEG_FULL) ? 21'h0ffff
                                        : 21'($urandom_range(seg_lo[3], 16'hfffe));
        write_half(0, FMT_SEG);
        write_half(2, 16'($urandom));
        write_half(4, 16'($urandom));
        write_half(6, 16'd8);
        for (int i = 8; i < 14; i += 2) write_half(i, 16'($urandom));
        for (int i = 0; i < 4; i++) write_half(14 + 2 * i, seg_hi[i][15:0]);
        write_half(22, 16'd0);
        for (int i = 0; i < 4; i++) write_half(24 + 2 * i, seg_lo[i][15:0]);
        for (int i = 0; i < 4; i++) write_half(32 + 2 * i, 16'($urandom));
        // plain delta, glyph array just past the table, offset far past memory
        write_half(40, 16'd0);
        write_half(42, 16'd6);
        write_half(44, 16'hffff);
        write_half(46, 16'd0);
        for (int i = 0; i < 8; i++)
          write_half(48 + 2 * i, (i == 2) ? 16'd0 : 16'($urandom));
      end
      TBL_GROUP, TBL_GROUP_EMPTY, TBL_GROUP_HUGE: begin
        n_groups = (k == TBL_GROUP) ? $urandom_range(1, 4) : 0;
        count = (k == TBL_GROUP_HUGE) ? 32'hffff_ffff : 32'(n_groups);
        write_half(0, FMT_GROUP);
        write_half(2, 16'($urandom));
        write_word(4, $urandom);
        write_word(8, $urandom);
        write_word(12, count);
        grp_lo[0] = 21'($urandom_range(0, 16'h40));
        for (int g = 0; g < n_groups; g++) begin
          if (g > 0) grp_lo[g] = grp_hi[g - 1] + 21'($urandom_range(1, 16'h8000));
          grp_hi[g] = grp_lo[g] + 21'($urandom_range(0, 16'h3000));
          write_word(16 + 12 * g, {11'd0, grp_lo[g]});
          write_word(20 + 12 * g, {11'd0, grp_hi[g]});
          write_word(24 + 12 * g, $urandom);
        end
      end
      default: begin
        do fmt = 16'($urandom); while (fmt == FMT_BYTE || fmt == FMT_SEG || fmt == FMT_GROUP);
        write_half(0, fmt);
      end
    endcase
  endtask

  // code points aimed at the interesting parts of the current table
  function automatic logic [20:0] pick_code();
    int j;
    j = $urandom_range(1, 3);
    case (kind)
      TBL_BYTE: begin
        case ($urandom_range(3))
          0, 1: return 21'($urandom_range(0, BYTE_CODES - 1));
          2: return 21'($urandom_range(256, 21'h10ffff));
          default: return SYMBOL_LIMIT;
        endcase
      end
      TBL_SEG_FULL, TBL_SEG_OPEN: begin
        case ($urandom_range(5))
          0: return 21'($urandom_range(seg_lo[j], seg_hi[j]));
          1: return seg_lo[j] - 21'd1;
          2: return 21'($urandom_range(0, 8'hff));
          3: return SYMBOL_BASE + 21'($urandom_range(0, 8'hff));
          4: return 21'($urandom_range(21'h10000, 21'h1fffff));
          default: return 21'($urandom_range(0, 16'hffff));
        endcase
      end
      TBL_GROUP: begin
        j = $urandom_range(0, n_groups - 1);
        case ($urandom_range(5))
          0, 1: return 21'($urandom_range(grp_lo[j], grp_hi[j]));
          2: return grp_hi[j] + 21'd1;
          3: return 21'($urandom_range(0, 8'hff));
          4: return SYMBOL_BASE + 21'($urandom_range(0, 8'hff));
          default: return 21'($urandom_range(0, 21'h1fffff));
        endcase
      end
      default: return ($urandom_range(1) == 1) ? 21'($urandom_range(0, 8'hff))
                                               : 21'($urandom_range(0, 21'h1fffff));
    endcase
  endfunction

  // stimulus
  initial begin
    logic [20:0] edge_codes [8];
    in_ch.valid = 1'b0;
    in_ch.mode = 1'b0;
    in_ch.table_address = '0;
    in_ch.table_byte = '0;
    in_ch.code_point = '0;
    in_ch.last_in_string = 1'b0;
    cfg.valid = 1'b0;
    cfg.index = CFG_SYMBOL_FONT;
    cfg.data = 1'b0;
    edge_codes = '{21'h0, 21'hff, 21'h100, 21'hffff, 21'h10000, 21'h10ffff,
                   21'h1fffff, 21'h0aaaa};
    rst = 1'b1;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // pass-through with no table, symbol flag both ways
    foreach (edge_codes[i]) lookup(edge_codes[i]);
    set_reg(CFG_SYMBOL_FONT, 1'b1);
    for (int i = 0; i < 4; i++) lookup(edge_codes[i]);

    for (int r = 0; r < 2; r++) begin
      for (int k = TBL_BYTE; k <= TBL_BAD_FMT; k++) begin
        kind = table_kind_t'(k);
        build_table(kind);
        set_reg(CFG_TABLE_PRESENT, 1'b1);
        for (int s = 0; s < 2; s++) begin
          set_reg(CFG_SYMBOL_FONT, s[0]);
          if (r == 0 && kind == TBL_SEG_FULL && s == 1) hold_asked++;
          repeat (4) lookup(pick_code());
        end
      end
      set_reg(CFG_TABLE_PRESENT, 1'b0);
      repeat (10) lookup(21'($urandom_range(0, 21'h1fffff)));
    end

    drain();
    repeat (200) @(negedge clk);
    $display("covered %0d table byte writes, %0d lookups over formats 0, 4, 12 and bad",
             n_writes, n_lookups);
    $display("headers, %0d register writes, %0d result words checked", n_cfg, checked);
    if (errors == 0 && pending == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
